// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions of the text console writer
// Field widths, character codes, operation codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default screen geometry
  localparam int SCREEN_COLUMNS_DEF    = 80;
  localparam int SCREEN_ROWS_DEF       = 25;
  localparam int FIRST_CONSOLE_ROW_DEF = 9;

  // payload field widths
  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int ROW_FIELD_W = 4;
  localparam int COL_FIELD_W = 7;
  localparam int POS_FIELD_W = 11;
  localparam int CELL_DATA_W = ATTR_W + CHAR_W;

  // register port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_TEXT_ATTR = 1'b0;

  // character and attribute codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET      = 8'h0A;
  localparam logic [ATTR_W-1:0] ATTR_CELL_RESET = 8'h07;

  typedef enum logic [OP_W-1:0] {
    OP_PUT     = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_RECOLOR = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // what one cycle of a sweep over the store does at the sweep counter
  typedef enum logic [2:0] {
    SW_NONE,
    SW_RESET,
    SW_BLANK,
    SW_COPY,
    SW_RECOLOR
  } sweep_t;

  // source of the word in the write stage
  typedef enum logic [1:0] {
    WR_DIRECT,
    WR_COPY,
    WR_RECOLOR
  } wr_sel_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PUT,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_RECOLOR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic   accept;
    logic   put;
    logic   rd_cell;
    logic   home;
    logic   cnt_clr;
    logic   load_out;
    sweep_t sweep;
  } tcw_cmd_t;

  typedef struct packed {
    op_t  op;
    logic put_scrolls;
    logic copy_last;
    logic sweep_last;
    logic out_free;
  } tcw_sts_t;

endpackage
`default_nettype wire

// ===== design/tcw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl: console operation sequencer
// Walks each operation through decode, its cell write, cell read or store sweep and the result load.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire tcw_sts_t sts,
  output tcw_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sweep = SW_NONE;
    case (state_r)
      ST_INIT: begin
        cmd.sweep = SW_RESET;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.cnt_clr = 1'b1;
        cmd.accept  = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.op)
          OP_PUT:     state_nxt = ST_PUT;
          OP_CLEAR: begin
            cmd.home  = 1'b1;
            state_nxt = ST_CLEAR;
          end
          OP_RECOLOR: state_nxt = ST_RECOLOR;
          OP_READ:    state_nxt = ST_READ;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = sts.put_scrolls ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        cmd.sweep = SW_COPY;
        if (sts.copy_last) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL, ST_CLEAR: begin
        cmd.sweep = SW_BLANK;
        if (sts.sweep_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RECOLOR: begin
        cmd.sweep = SW_RECOLOR;
        if (sts.sweep_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        cmd.rd_cell = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the item finished");
`endif

endmodule
`default_nettype wire

// ===== design/tcw_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath: cell store, cursor and result register
// Executes controller commands: single cell writes, store sweeps through a
// one-deep write stage, cell reads and the result beat.
// ----------------------------------------------------------------------------
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS    = SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS       = SCREEN_ROWS_DEF,
  parameter int FIRST_CONSOLE_ROW = FIRST_CONSOLE_ROW_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tcw_cmd_t               cmd,
  output tcw_sts_t                    sts,
  input  wire logic [ATTR_W-1:0]      text_attr,
  input  wire logic [OP_W-1:0]        in_opcode,
  input  wire logic [CHAR_W-1:0]      in_char_code,
  input  wire logic [ROW_FIELD_W-1:0] in_read_row,
  input  wire logic [COL_FIELD_W-1:0] in_read_col,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [COL_FIELD_W-1:0]      out_cursor_col,
  output logic [ROW_FIELD_W-1:0]      out_cursor_row,
  output logic [POS_FIELD_W-1:0]      out_cursor_position,
  output logic [CHAR_W-1:0]           out_read_char,
  output logic [ATTR_W-1:0]           out_read_attribute
);

  localparam int CONSOLE_ROWS = SCREEN_ROWS - 1 - FIRST_CONSOLE_ROW;
  localparam int CELL_COUNT   = CONSOLE_ROWS * SCREEN_COLUMNS;
  localparam int CELL_W       = $clog2(CELL_COUNT);
  localparam int COL_W        = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W        = (CONSOLE_ROWS > 1) ? $clog2(CONSOLE_ROWS) : 1;

  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(CONSOLE_ROWS - 1);
  localparam logic [CELL_W-1:0] COPY_LAST = CELL_W'(CELL_COUNT - SCREEN_COLUMNS - 1);
  localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELL_COUNT - 1);
  localparam logic [CELL_W-1:0] ROW_STEP  = CELL_W'(SCREEN_COLUMNS);
  localparam logic [CELL_DATA_W-1:0] RESET_WORD = {ATTR_CELL_RESET, CH_SPACE};

  // latched item
  op_t                    op_r;
  logic [CHAR_W-1:0]      ch_r;
  logic [ROW_FIELD_W-1:0] rr_r;
  logic [COL_FIELD_W-1:0] rc_r;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CELL_W-1:0] cnt_r, cnt_nxt;

  // write stage
  logic                   wr_en_r, wr_en_nxt;
  logic [CELL_W-1:0]      wr_addr_r, wr_addr_nxt;
  wr_sel_t                wr_sel_r, wr_sel_nxt;
  logic [CELL_DATA_W-1:0] wr_data_r, wr_data_nxt;
  logic [CELL_DATA_W-1:0] wr_word;

  logic [CELL_DATA_W-1:0] mem [CELL_COUNT];
  logic [CELL_DATA_W-1:0] rdata_r;
  logic                   rd_en;
  logic [CELL_W-1:0]      rd_addr;

  logic [CELL_DATA_W-1:0] blank_word;
  logic                   is_nl, is_bs, at_last_col, at_last_row, at_col0;
  logic [COL_W-1:0]       put_col;
  logic [CELL_W-1:0]      put_addr;
  logic                   rd_ok;
  logic [CELL_W-1:0]      cell_addr;

  logic                   out_valid_r;
  logic [COL_FIELD_W-1:0] out_col_r;
  logic [ROW_FIELD_W-1:0] out_row_r;
  logic [POS_FIELD_W-1:0] out_pos_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic [ATTR_W-1:0]      out_attr_r;
  logic                   out_free;

  assign blank_word  = {text_attr, CH_SPACE};
  assign is_nl       = (ch_r == CH_NEWLINE);
  assign is_bs       = (ch_r == CH_BACKSPACE);
  assign at_last_col = (col_r == LAST_COL);
  assign at_last_row = (row_r == LAST_ROW);
  assign at_col0     = (col_r == '0);
  assign put_col     = is_bs ? (col_r - COL_W'(1)) : col_r;
  assign put_addr    = CELL_W'(int'(row_r) * SCREEN_COLUMNS + int'(put_col));
  assign rd_ok       = (int'(rr_r) < CONSOLE_ROWS) && (int'(rc_r) < SCREEN_COLUMNS);
  assign cell_addr   = rd_ok ? CELL_W'(int'(rr_r) * SCREEN_COLUMNS + int'(rc_r)) : '0;
  assign rd_en       = cmd.rd_cell || (cmd.sweep inside {SW_COPY, SW_RECOLOR});

  always_comb begin
    if (cmd.rd_cell) begin
      rd_addr = cell_addr;
    end else if (cmd.sweep == SW_COPY) begin
      rd_addr = cnt_r + ROW_STEP;
    end else begin
      rd_addr = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= op_t'(in_opcode);
      ch_r <= in_char_code;
      rr_r <= in_read_row;
      rc_r <= in_read_col;
    end
  end

  // cursor, sweep counter and write stage
  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    cnt_nxt     = cnt_r;
    wr_en_nxt   = 1'b0;
    wr_addr_nxt = wr_addr_r;
    wr_sel_nxt  = WR_DIRECT;
    wr_data_nxt = wr_data_r;

    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.sweep != SW_NONE) begin
      cnt_nxt = cnt_r + CELL_W'(1);
    end

    if (cmd.home) begin
      col_nxt = '0;
      row_nxt = '0;
    end

    if (cmd.put) begin
      if (is_nl) begin
        col_nxt = '0;
        if (!at_last_row) begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else if (is_bs) begin
        if (!at_col0) begin
          col_nxt     = put_col;
          wr_en_nxt   = 1'b1;
          wr_addr_nxt = put_addr;
          wr_data_nxt = blank_word;
        end
      end else begin
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = put_addr;
        wr_data_nxt = {text_attr, ch_r};
        if (at_last_col) begin
          col_nxt = '0;
          if (!at_last_row) begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
    end

    case (cmd.sweep)
      SW_RESET: begin
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = cnt_r;
        wr_data_nxt = RESET_WORD;
      end
      SW_BLANK: begin
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = cnt_r;
        wr_data_nxt = blank_word;
      end
      SW_COPY: begin
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = cnt_r;
        wr_sel_nxt  = WR_COPY;
      end
      SW_RECOLOR: begin
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = cnt_r;
        wr_sel_nxt  = WR_RECOLOR;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (wr_sel_r)
      WR_COPY:    wr_word = rdata_r;
      WR_RECOLOR: wr_word = {text_attr, rdata_r[CHAR_W-1:0]};
      default:    wr_word = wr_data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
      wr_en_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cnt_r   <= cnt_nxt;
      wr_en_r <= wr_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
    wr_sel_r  <= wr_sel_nxt;
    wr_data_r <= wr_data_nxt;
  end

  // cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      mem[wr_addr_r] <= wr_word;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // result register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_col_r <= COL_FIELD_W'(col_r);
      out_row_r <= ROW_FIELD_W'(row_r);
      out_pos_r <= POS_FIELD_W'((FIRST_CONSOLE_ROW + int'(row_r)) * SCREEN_COLUMNS
                                + int'(col_r));
      if (op_r == OP_READ && rd_ok) begin
        out_char_r <= rdata_r[CHAR_W-1:0];
        out_attr_r <= rdata_r[CELL_DATA_W-1:CHAR_W];
      end else begin
        out_char_r <= '0;
        out_attr_r <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_col      = out_col_r;
  assign out_cursor_row      = out_row_r;
  assign out_cursor_position = out_pos_r;
  assign out_read_char       = out_char_r;
  assign out_read_attribute  = out_attr_r;

  assign sts.op          = op_r;
  assign sts.put_scrolls = at_last_row && (is_nl || (!is_bs && at_last_col));
  assign sts.copy_last   = (cnt_r == COPY_LAST);
  assign sts.sweep_last  = (cnt_r == CELL_LAST);
  assign sts.out_free    = out_free;

`ifndef ASSERT_OFF
  a_cursor_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(col_r) < SCREEN_COLUMNS) && (int'(row_r) < CONSOLE_ROWS))
    else $error("cursor left the console area");

  a_scroll_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep == SW_COPY) && wr_en_r |-> wr_addr_r != rd_addr)
    else $error("scroll read meets its own pending write");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire

// ===== design/text_console_writer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_top: text console engine
// Character/attribute store of the console rows with cursor handling, scroll,
// clear, recolor and cell read, plus the text attribute register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per beat:
//   put character, clear area, recolor area or read cell. Every operation
//   returns exactly one beat on the result channel (out_valid/out_ready)
//   with the cursor after the operation, its absolute screen index, and the
//   read cell (zero unless a read hits the area).
//   Steps: decode, then a put writes its cell and moves the cursor (scrolling
//   the store up one row when it runs past the last row), a read fetches the
//   cell, and clear and recolor sweep the whole store; then the result loads.
//   Scroll, clear and recolor walk the store one cell per cycle through its
//   single write port; that sweep sets the throughput of those operations.
//   One operation is in flight at a time; the next is accepted only once
//   the current one has loaded its result.
//   Reset: after rst_n releases, all CELL_COUNT cells (1200 with the default
//   geometry) are filled with blanks in attribute 0x07 with in_ready low.
//   Register writes are taken throughout. text_attribute resets to 0x0A.
//   Receiver stall: the result sits in its output register; the next item is
//   still accepted and runs, and finishes once the register is free.
// ----------------------------------------------------------------------------
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS    = SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS       = SCREEN_ROWS_DEF,
  parameter int FIRST_CONSOLE_ROW = FIRST_CONSOLE_ROW_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // register port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]          prdata,
  output logic                        pready,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [OP_W-1:0]        in_opcode,
  input  wire logic [CHAR_W-1:0]      in_char_code,
  input  wire logic [ROW_FIELD_W-1:0] in_read_row,
  input  wire logic [COL_FIELD_W-1:0] in_read_col,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [COL_FIELD_W-1:0]      out_cursor_col,
  output logic [ROW_FIELD_W-1:0]      out_cursor_row,
  output logic [POS_FIELD_W-1:0]      out_cursor_position,
  output logic [CHAR_W-1:0]           out_read_char,
  output logic [ATTR_W-1:0]           out_read_attribute
);

  logic [ATTR_W-1:0] attr_r;
  logic              reg_sel;
  logic              reg_wr;
  tcw_cmd_t          cmd;
  tcw_sts_t          sts;

  // Register port: zero wait states; the index sits above the byte offset.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[REG_SEL_BIT] == REG_TEXT_ATTR);
  assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? PDATA_W'(attr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (reg_wr) begin
      attr_r <= pwdata[ATTR_W-1:0];
    end
  end

  // Sequencer: owns the state machine, issues one command set per cycle.
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, cursor and result register.
  tcw_datapath #(
    .SCREEN_COLUMNS    (SCREEN_COLUMNS),
    .SCREEN_ROWS       (SCREEN_ROWS),
    .FIRST_CONSOLE_ROW (FIRST_CONSOLE_ROW)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .text_attr           (attr_r),
    .in_opcode           (in_opcode),
    .in_char_code        (in_char_code),
    .in_read_row         (in_read_row),
    .in_read_col         (in_read_col),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_col      (out_cursor_col),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_position (out_cursor_position),
    .out_read_char       (out_read_char),
    .out_read_attribute  (out_read_attribute)
  );

endmodule
`default_nettype wire
